/* sv/c3f_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_pkg: shared types and constants of the 3x3 convolution filter
// Sizes, configuration register codes, the settings bundle and the item
// bundles that pass between the window, arithmetic and output stages.
// ----------------------------------------------------------------------------
package c3f_pkg;

  // Line store depth and widest channel stride
  localparam int LINE_MAX   = 4096;
  localparam int MAX_STRIDE = 3;
  localparam int KSIZE      = 3;

  localparam int COL_W   = $clog2(LINE_MAX);      // column address bits
  localparam int EW      = COL_W + 1;             // effective width, holds LINE_MAX
  localparam int WIN_N   = 2 * MAX_STRIDE;        // stored taps per row
  localparam int WIN_IW  = (WIN_N > 1) ? $clog2(WIN_N) : 1;

  // Field widths fixed by the interface
  localparam int PIX_W     = 8;
  localparam int RAW_W_W   = 13;
  localparam int HEIGHT_W  = 16;
  localparam int STRIDE_W  = 2;
  localparam int COEF_W    = 16;
  localparam int KROW_W    = KSIZE * COEF_W;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 12;

  // Arithmetic widths
  localparam int PROD_W = PIX_W + 1 + COEF_W;     // unsigned byte times signed weight
  localparam int ROW_W  = PROD_W + 2;             // sum of three products
  localparam int TOT_W  = ROW_W + 2;              // sum of three rows

  // Output queue
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_STRIDE = 3'd2,
    REG_KTOP   = 3'd3,
    REG_KMID   = 3'd4,
    REG_KBOT   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [EW-1:0]                   width;   // 1..LINE_MAX
    logic [HEIGHT_W-1:0]             height;
    logic [STRIDE_W-1:0]             stride;  // 1..MAX_STRIDE
    logic [KSIZE-1:0][KROW_W-1:0]    kernel;  // [0] top, [1] mid, [2] bottom
  } cfg_t;

  // Neighborhood of one centre: pix[row][col], col 0 = left, col 2 = right
  typedef struct packed {
    logic                                     valid;
    logic                                     last;
    logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0]   pix;
  } taps_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [PIX_W-1:0] data;
  } res_t;

  function automatic logic [EW-1:0] eff_width(input logic [RAW_W_W-1:0] raw);
    logic [31:0] v;
    v = 32'(raw);
    if (v == 32'd0) v = 32'd1;
    if (v > 32'(LINE_MAX)) v = 32'(LINE_MAX);
    return v[EW-1:0];
  endfunction

  function automatic logic [STRIDE_W-1:0] eff_stride(input logic [STRIDE_W-1:0] raw);
    logic [31:0] v;
    v = 32'(raw);
    if (v == 32'd0) v = 32'd1;
    if (v > 32'(MAX_STRIDE)) v = 32'(MAX_STRIDE);
    return v[STRIDE_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/c3f_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_in_if: input sample channel
// Valid/ready channel carrying one raster byte and its frame start mark.
// ----------------------------------------------------------------------------
interface c3f_in_if;
  logic                     valid;
  logic                     ready;
  logic [c3f_pkg::PIX_W-1:0] sample;
  logic                     frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface
`default_nettype wire

/* sv/c3f_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_out_if: filtered result channel
// Valid/ready channel carrying one filtered byte and its frame end mark.
// ----------------------------------------------------------------------------
interface c3f_out_if;
  logic                     valid;
  logic                     ready;
  logic [c3f_pkg::PIX_W-1:0] filtered;
  logic                     frame_end;

  modport source (output valid, output filtered, output frame_end, input ready);
  modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface
`default_nettype wire

/* sv/c3f_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface c3f_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [c3f_pkg::CFG_IDX_W-1:0] index;
  logic [c3f_pkg::KROW_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/conv3x3_image_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_image_filter: 3x3 convolution over a padded 8-bit raster
// Streams a padded frame in raster order and returns the clamped 3x3
// weighted sum of every interior byte.
// ----------------------------------------------------------------------------
// Takes one byte of a padded frame per clock (halo ring included, grey or
// interleaved RGB with horizontal neighbors channel_stride bytes apart) and
// returns one filtered byte for every interior position, in raster order,
// with frame_end on the last one of the frame. The result for centre
// (r-1, c-s) leaves after byte (r, c) is taken, through the read stage and
// the tap, product, row-sum and queue registers. Sustained rate is one item
// per clock; the input only holds off when eight results are owed to a
// stalled output (depth of the output queue). The two previous rows live in
// one 4096 x 16 line memory read and written once per item; a back-to-back
// read of the entry just written (one-column rows, frame restart at column
// 0) takes the value from a forward path. The line memory needs no clearing
// pass: only the first two rows read stale entries and use none of them.
// frame_start restarts the raster counters at once; without it the counters
// wrap after the last byte of the frame. Weights are signed Q4.12, left
// weight in bits 15:0 of each kernel row, centre in 31:16, right in 47:32.
// The sum is exact, truncated toward zero and clamped to 0..255. Widths of
// 0 act as 1, above 4096 as 4096; stride 0 acts as 1. Configuration is
// written only while no item is in flight: a rule for the user, unenforced.
// ----------------------------------------------------------------------------
module conv3x3_image_filter (
  input  wire logic clk,
  input  wire logic rst,
  c3f_in_if.sink    pix_in,
  c3f_out_if.source pix_out,
  c3f_cfg_if.sink   cfg
);
  import c3f_pkg::*;

  cfg_t  cfg_q;      // effective settings
  logic  credit_ok;  // output queue can take one more result
  logic  claim;      // accepted item will produce a result
  taps_t taps;       // neighborhood of one centre
  res_t  res;        // clamped result

  // Config port never stalls
  assign cfg.ready = 1'b1;

  // Register file; width and stride kept already clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.width     <= eff_width(RAW_W_W'(LINE_MAX));
      cfg_q.height    <= HEIGHT_W'(3);
      cfg_q.stride    <= STRIDE_W'(1);
      cfg_q.kernel[0] <= '0;
      cfg_q.kernel[1] <= KROW_W'(48'h0000_1000_0000);  // identity
      cfg_q.kernel[2] <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_WIDTH:  cfg_q.width     <= eff_width(cfg.data[RAW_W_W-1:0]);
        REG_HEIGHT: cfg_q.height    <= cfg.data[HEIGHT_W-1:0];
        REG_STRIDE: cfg_q.stride    <= eff_stride(cfg.data[STRIDE_W-1:0]);
        REG_KTOP:   cfg_q.kernel[0] <= cfg.data;
        REG_KMID:   cfg_q.kernel[1] <= cfg.data;
        REG_KBOT:   cfg_q.kernel[2] <= cfg.data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Raster counters, line memory, tap window
  c3f_window u_window (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in),
    .cfg       (cfg_q),
    .credit_ok (credit_ok),
    .claim     (claim),
    .taps      (taps)
  );

  // Products, row sums, total and clamp
  c3f_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_q),
    .taps (taps),
    .res  (res)
  );

  // Result queue and input credit
  c3f_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .claim     (claim),
    .res       (res),
    .pix_out   (pix_out),
    .credit_ok (credit_ok)
  );

endmodule
`default_nettype wire

/* sv/c3f_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_window: raster position, line memory and tap window
// Reads the two stored rows at the current column, writes them back shifted
// down one row, and gathers the 3x3 neighborhood of each interior centre.
// ----------------------------------------------------------------------------
module c3f_window (
  input  wire logic          clk,
  input  wire logic          rst,
  c3f_in_if.sink             pix_in,
  input  wire c3f_pkg::cfg_t cfg,
  input  wire logic          credit_ok,
  output logic               claim,
  output c3f_pkg::taps_t     taps
);
  import c3f_pkg::*;

  // Line memory: [15:8] row r-2, [7:0] row r-1
  logic [2*PIX_W-1:0] line_mem [LINE_MAX];
  logic [2*PIX_W-1:0] rd_data;

  logic [COL_W-1:0]    col_count;
  logic [HEIGHT_W-1:0] row_count;

  logic                accept;
  logic [COL_W-1:0]    c;
  logic [HEIGHT_W-1:0] r;
  logic [EW-1:0]       c_ext;
  logic                last_col;
  logic                produce;
  logic                last_item;
  logic [COL_W-1:0]    col_count_next;
  logic [HEIGHT_W-1:0] row_count_next;
  logic [HEIGHT_W:0]   r_inc;

  // Read stage
  logic                s1_valid;
  logic [COL_W-1:0]    s1_c;
  logic [PIX_W-1:0]    s1_sample;
  logic                s1_prod;
  logic                s1_last;
  logic                s1_fwd;
  logic [PIX_W-1:0]    s1_fwd_up;
  logic [PIX_W-1:0]    s1_fwd_lo;
  logic [PIX_W-1:0]    up;
  logic [PIX_W-1:0]    lo;

  logic [PIX_W-1:0]  win [KSIZE][WIN_N];
  logic [PIX_W-1:0]  fresh [KSIZE];
  logic [WIN_IW-1:0] ci;
  logic [WIN_IW-1:0] li;

  assign pix_in.ready = credit_ok;
  assign accept       = pix_in.valid && credit_ok;

  always_comb begin
    c        = pix_in.frame_start ? '0 : col_count;
    r        = pix_in.frame_start ? '0 : row_count;
    c_ext    = EW'(c);
    last_col = (c_ext + EW'(1)) >= cfg.width;
    r_inc    = {1'b0, r} + (HEIGHT_W+1)'(1);
    produce  = (r >= HEIGHT_W'(2)) && (r < cfg.height) &&
               (c_ext >= EW'({cfg.stride, 1'b0})) && (c_ext < cfg.width);
    last_item = (r == (cfg.height - HEIGHT_W'(1))) && (c_ext == (cfg.width - EW'(1)));
    if (last_col) begin
      col_count_next = '0;
      row_count_next = (r_inc >= {1'b0, cfg.height}) ? '0 : r_inc[HEIGHT_W-1:0];
    end else begin
      col_count_next = c + COL_W'(1);
      row_count_next = r;
    end
  end

  assign claim = accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
    end
  end

  // Item in the read stage writes back at the same edge that a new item
  // reads; the memory returns the old word then, so forward the new one.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c      <= c;
      s1_sample <= pix_in.sample;
      s1_prod   <= produce;
      s1_last   <= last_item;
      s1_fwd    <= s1_valid && (s1_c == c);
      s1_fwd_up <= lo;
      s1_fwd_lo <= s1_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[c];
    end
    if (s1_valid) begin
      line_mem[s1_c] <= {lo, s1_sample};
    end
  end

  assign up = s1_fwd ? s1_fwd_up : rd_data[2*PIX_W-1:PIX_W];
  assign lo = s1_fwd ? s1_fwd_lo : rd_data[PIX_W-1:0];

  assign fresh[0] = up;
  assign fresh[1] = lo;
  assign fresh[2] = s1_sample;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int row = 0; row < KSIZE; row++) begin
        win[row][0] <= fresh[row];
        for (int k = 1; k < WIN_N; k++) begin
          win[row][k] <= win[row][k-1];
        end
      end
    end
  end

  // Centre is s back and left is 2s back, one place less before the shift
  assign ci = WIN_IW'(cfg.stride) - WIN_IW'(1);
  assign li = WIN_IW'({cfg.stride, 1'b0}) - WIN_IW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      taps.valid <= 1'b0;
    end else begin
      taps.valid <= s1_valid && s1_prod;
    end
    taps.last <= s1_last;
    for (int row = 0; row < KSIZE; row++) begin
      taps.pix[row][2] <= fresh[row];
      taps.pix[row][1] <= win[row][ci];
      taps.pix[row][0] <= win[row][li];
    end
  end

endmodule
`default_nettype wire

/* sv/c3f_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_mac: weighted sum and clamp
// Nine products, then three row sums, then the total, truncated toward zero
// and clamped to the byte range.
// ----------------------------------------------------------------------------
module c3f_mac (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire c3f_pkg::cfg_t  cfg,
  input  wire c3f_pkg::taps_t taps,
  output c3f_pkg::res_t       res
);
  import c3f_pkg::*;

  logic signed [PROD_W-1:0] prod_q [KSIZE][KSIZE];
  logic signed [ROW_W-1:0]  row_q  [KSIZE];
  logic                     p_valid, p_last;
  logic                     r_valid, r_last;
  logic signed [TOT_W-1:0]  total;
  logic [TOT_W-FRAC_W-1:0]  scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      p_valid <= taps.valid;
      r_valid <= p_valid;
    end
  end

  // Byte zero-extended and weight sign-extended to the full product width
  always_ff @(posedge clk) begin
    p_last <= taps.last;
    r_last <= p_last;
    for (int row = 0; row < KSIZE; row++) begin
      for (int col = 0; col < KSIZE; col++) begin
        prod_q[row][col] <= $signed(PROD_W'({1'b0, taps.pix[row][col]})) *
                            PROD_W'($signed(cfg.kernel[row][col*COEF_W +: COEF_W]));
      end
      row_q[row] <= ROW_W'(prod_q[row][0]) + ROW_W'(prod_q[row][1]) +
                    ROW_W'(prod_q[row][2]);
    end
  end

  always_comb begin
    total  = TOT_W'(row_q[0]) + TOT_W'(row_q[1]) + TOT_W'(row_q[2]);
    scaled = total[TOT_W-1:FRAC_W];
    res.valid = r_valid;
    res.last  = r_last;
    if (total[TOT_W-1]) begin
      res.data = '0;
    end else if (scaled > (TOT_W-FRAC_W)'(255)) begin
      res.data = '1;
    end else begin
      res.data = scaled[PIX_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* sv/c3f_outq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3f_outq: result queue with credit count
// Holds finished results; counts results claimed at the input but not yet
// taken, and closes the input when that count reaches the queue depth.
// ----------------------------------------------------------------------------
module c3f_outq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          claim,
  input  wire c3f_pkg::res_t res,
  c3f_out_if.source          pix_out,
  output logic               credit_ok
);
  import c3f_pkg::*;

  logic [PIX_W:0]    entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] pending;
  logic [QCNT_W-1:0] count_next;
  logic [QCNT_W-1:0] pending_next;
  logic              pop;

  assign pix_out.valid     = (count != '0);
  assign pix_out.filtered  = entry[rd_ptr][PIX_W-1:0];
  assign pix_out.frame_end = entry[rd_ptr][PIX_W];
  assign pop               = pix_out.valid && pix_out.ready;
  assign credit_ok         = (pending < QCNT_W'(QDEPTH));

  always_comb begin
    count_next   = count + QCNT_W'(res.valid) - QCNT_W'(pop);
    pending_next = pending + QCNT_W'(claim) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      pending <= '0;
    end else begin
      count   <= count_next;
      pending <= pending_next;
      if (res.valid) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)       rd_ptr <= rd_ptr + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      entry[wr_ptr] <= {res.last, res.data};
    end
  end

endmodule
`default_nettype wire
